@@ sv/bank_mapper_scanline_irq_core_macros.svh @@
// assertion macros for the bank mapper core
// used by the top level only, no other dependencies
`ifndef BANK_MAPPER_SCANLINE_IRQ_CORE_MACROS_SVH
`define BANK_MAPPER_SCANLINE_IRQ_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define BMSI_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("bmsi assertion failed");

// condition implies consequence in the next cycle
`define BMSI_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("bmsi assertion failed");

`endif

@@ sv/bmsi_pkg.sv @@
// shared types and constants of the bank mapper core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmsi_pkg;

    localparam int NUM_BANK_REGS = 8;
    localparam int BANK_IDX_W    = $clog2(NUM_BANK_REGS);
    localparam int MOD_W         = 11;
    localparam int PAGE_W        = 9;

    // transaction kinds
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_TICK  = 3'd1;
    localparam logic [2:0] KIND_FRAME = 3'd2;
    localparam logic [2:0] KIND_CPU   = 3'd3;
    localparam logic [2:0] KIND_PPU   = 3'd4;

    // register write decode
    localparam logic [15:0] DEC_MASK     = 16'he001;
    localparam logic [15:0] DEC_MIRROR   = 16'ha000;
    localparam logic [15:0] DEC_IRQ_CNT  = 16'hc000;
    localparam logic [15:0] DEC_IRQ_RLD  = 16'hc001;
    localparam logic [15:0] DEC_IRQ_OFF  = 16'he000;
    localparam logic [15:0] DEC_IRQ_ON   = 16'he001;
    localparam logic [15:0] DEC_BANK_SEL = 16'h8000;
    localparam logic [15:0] DEC_BANK_DAT = 16'h8001;

    localparam logic [7:0]  PAIR_MASK      = 8'hfe;
    localparam logic [8:0]  TICK_LAST_LINE = 9'd239;
    localparam logic [15:0] CPU_ROM_BASE   = 16'h8000;
    localparam logic [15:0] PPU_TOP        = 16'h2000;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG  = 2'd0;
    localparam logic [1:0] CFG_CHR  = 2'd1;
    localparam logic [1:0] CFG_FOUR = 2'd2;

    typedef logic [NUM_BANK_REGS-1:0][7:0] bank_vec_t;

    // entry 7 first
    localparam bank_vec_t BANK_RESET = {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

    typedef struct packed {
        logic             start;
        logic [7:0]       dividend;
        logic [MOD_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

@@ sv/bmsi_mod_unit.sv @@
// iterative remainder unit, one restoring step per cycle
// depends on bmsi_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmsi_mod_unit
    import bmsi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mod_req_t req,
    output mod_rsp_t      rsp
);

    logic [MOD_W-1:0] rem_reg, rem_next;
    logic [MOD_W-1:0] div_reg, div_next;
    logic [7:0]       dvd_reg, dvd_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [MOD_W:0]   trial;

    // shift in one dividend bit, subtract when it fits
    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[7]};
        if (req.start)
        begin
            rem_next = '0;
            div_next = req.divisor;
            dvd_next = req.dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = MOD_W'(trial - {1'b0, div_reg});
            else
                rem_next = MOD_W'(trial);
            dvd_next = {dvd_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[7:0];

endmodule

`default_nettype wire

@@ sv/bmsi_page_xlat.sv @@
// address to page translation for cpu and ppu lookups
// depends on bmsi_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmsi_page_xlat
    import bmsi_pkg::*;
(
    input  wire logic              is_ppu,
    input  wire logic [15:0]       address,
    input  wire logic              prg_swap,
    input  wire logic              chr_swap,
    input  wire logic [7:0]        prg_size,
    input  wire bank_vec_t         banks,
    output logic      [PAGE_W-1:0] page
);

    logic [PAGE_W-1:0]     prg_pages;
    logic [PAGE_W-1:0]     last_page;
    logic [PAGE_W-1:0]     second_page;
    logic [1:0]            cpu_sel;
    logic [2:0]            slot;
    logic [BANK_IDX_W-1:0] rd_idx;
    logic [7:0]            rd_val;

    assign prg_pages   = {prg_size, 1'b0};
    assign last_page   = prg_pages - 9'd1;
    assign second_page = prg_pages - 9'd2;
    assign cpu_sel     = address[14:13];
    assign slot        = address[12:10] ^ {chr_swap, 2'b00};

    // single bank read index
    always_comb
    begin
        if (is_ppu)
        begin
            if (!slot[2])
                rd_idx = {2'b00, slot[1]};
            else
                rd_idx = slot - 3'd2;
        end
        else if (cpu_sel == 2'd1)
            rd_idx = 3'd7;
        else
            rd_idx = 3'd6;
    end

    assign rd_val = banks[rd_idx];

    // page selection
    always_comb
    begin
        page = '0;
        if (is_ppu)
        begin
            if (address < PPU_TOP)
            begin
                if (!slot[2])
                    page = {1'b0, rd_val} + {8'd0, slot[0]};
                else
                    page = {1'b0, rd_val};
            end
        end
        else if (address >= CPU_ROM_BASE)
        begin
            case (cpu_sel)
                2'd0:    page = prg_swap ? second_page : {1'b0, rd_val};
                2'd1:    page = {1'b0, rd_val};
                2'd2:    page = prg_swap ? {1'b0, rd_val} : second_page;
                default: page = last_page;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/bank_mapper_scanline_irq_core.sv @@
// top level of the bank mapper core: sequencer, mapper state, config port
// depends on bmsi_pkg, bmsi_mod_unit, bmsi_page_xlat and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "bank_mapper_scanline_irq_core_macros.svh"

// Usage
// A transaction is taken at a rising edge with start high and busy low; kind,
// address, data, scanline and rendering_on are sampled there. Every
// transaction gives one result on page, irq and mirroring, marked by a
// one-cycle done strobe. The receiver cannot stall; the result is gone after
// that cycle, and mirroring shows the current mode at all times.
// Ticks, frame starts, lookups and most register writes pass from accept
// through the execute state to done. A bank data write, unless dropped for a
// zero pattern size, runs its value through the shared remainder unit, one
// restoring step per cycle for the 8 data bits. busy is low again in the
// done cycle, so a new transaction can be taken while the result is shown.
// The APB port (word registers at 0, 4, 8) holds program size, pattern size
// and four-screen mode; write it only while idle.
// Reset is asynchronous, active low, and restores the bank registers to
// their power-on layout and clears counter, irq enable and mirroring.

module bank_mapper_scanline_irq_core
    import bmsi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        kind,
    input  wire logic [15:0]       address,
    input  wire logic [7:0]        data,
    input  wire logic [8:0]        scanline,
    input  wire logic              rendering_on,
    output logic                   done,
    output logic      [PAGE_W-1:0] page,
    output logic                   irq,
    output logic                   mirroring,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;

    logic [1:0]  state_reg, state_next;

    // sampled transaction
    logic [2:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [8:0]  line_reg;
    logic        rend_reg;

    // configuration
    logic [7:0]  prg_size_reg;
    logic [7:0]  chr_size_reg;
    logic        four_reg;

    // mapper state
    bank_vec_t             bank_reg, bank_next;
    logic [BANK_IDX_W-1:0] target_reg, target_next;
    logic                  chr_swap_reg, chr_swap_next;
    logic                  prg_swap_reg, prg_swap_next;
    logic [7:0]            cnt_reg, cnt_next;
    logic [7:0]            reload_reg, reload_next;
    logic                  irq_on_reg, irq_on_next;
    logic                  mirror_reg, mirror_next;

    // result
    logic              done_reg, done_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              irq_reg, irq_next;

    logic              accept;
    logic              cfg_wr;
    logic              finish;
    logic [7:0]        cnt_dec;
    logic [PAGE_W-1:0] xlat_page;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cnt_dec = cnt_reg - 8'd1;

    bmsi_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    bmsi_page_xlat u_xlat (
        .is_ppu   (kind_reg == KIND_PPU),
        .address  (addr_reg),
        .prg_swap (prg_swap_reg),
        .chr_swap (chr_swap_reg),
        .prg_size (prg_size_reg),
        .banks    (bank_reg),
        .page     (xlat_page)
    );

    // sequencer and mapper state update
    always_comb
    begin
        state_next       = state_reg;
        bank_next        = bank_reg;
        target_next      = target_reg;
        chr_swap_next    = chr_swap_reg;
        prg_swap_next    = prg_swap_reg;
        cnt_next         = cnt_reg;
        reload_next      = reload_reg;
        irq_on_next      = irq_on_reg;
        mirror_next      = mirror_reg;
        done_next        = 1'b0;
        page_next        = page_reg;
        irq_next         = irq_reg;
        finish           = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = (target_reg < 3'd2) ? (data_reg & PAIR_MASK) : data_reg;
        mod_req.divisor  = (target_reg[2:1] == 2'b11) ? {2'b00, prg_size_reg, 1'b0}
                                                      : {chr_size_reg, 3'b000};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                finish    = 1'b1;
                page_next = '0;
                irq_next  = 1'b0;
                case (kind_reg)
                    KIND_WRITE:
                    begin
                        case (addr_reg & DEC_MASK)
                            DEC_MIRROR:
                            begin
                                if (!four_reg)
                                    mirror_next = data_reg[0];
                            end
                            DEC_IRQ_CNT:  cnt_next    = data_reg;
                            DEC_IRQ_RLD:  reload_next = data_reg;
                            DEC_IRQ_OFF:  irq_on_next = 1'b0;
                            DEC_IRQ_ON:   irq_on_next = 1'b1;
                            DEC_BANK_SEL:
                            begin
                                chr_swap_next = data_reg[7];
                                prg_swap_next = data_reg[6];
                                target_next   = data_reg[2:0];
                            end
                            DEC_BANK_DAT:
                            begin
                                // no pattern rom: pattern bank writes are dropped
                                if (target_reg[2:1] == 2'b11 || chr_size_reg != 8'd0)
                                begin
                                    finish        = 1'b0;
                                    mod_req.start = 1'b1;
                                    state_next    = ST_MOD;
                                end
                            end
                            default: ;
                        endcase
                    end
                    KIND_TICK:
                    begin
                        if (irq_on_reg && line_reg <= TICK_LAST_LINE && rend_reg)
                        begin
                            if (cnt_dec == 8'd0)
                            begin
                                cnt_next = reload_reg;
                                irq_next = 1'b1;
                            end
                            else
                                cnt_next = cnt_dec;
                        end
                    end
                    KIND_FRAME: cnt_next  = reload_reg;
                    KIND_CPU:   page_next = xlat_page;
                    KIND_PPU:   page_next = xlat_page;
                    default: ;
                endcase
                if (finish)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    bank_next[target_reg] = mod_rsp.rem;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bank_reg     <= BANK_RESET;
            target_reg   <= '0;
            chr_swap_reg <= 1'b0;
            prg_swap_reg <= 1'b0;
            cnt_reg      <= '0;
            reload_reg   <= '0;
            irq_on_reg   <= 1'b0;
            mirror_reg   <= 1'b0;
            done_reg     <= 1'b0;
            prg_size_reg <= 8'd2;
            chr_size_reg <= 8'd1;
            four_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            target_reg   <= target_next;
            chr_swap_reg <= chr_swap_next;
            prg_swap_reg <= prg_swap_next;
            cnt_reg      <= cnt_next;
            reload_reg   <= reload_next;
            irq_on_reg   <= irq_on_next;
            mirror_reg   <= mirror_next;
            done_reg     <= done_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    CFG_PRG:  prg_size_reg <= pwdata[7:0];
                    CFG_CHR:  chr_size_reg <= pwdata[7:0];
                    CFG_FOUR: four_reg     <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // sampled transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            data_reg <= data;
            line_reg <= scanline;
            rend_reg <= rendering_on;
        end
        page_reg <= page_next;
        irq_reg  <= irq_next;
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            CFG_PRG:  prdata = {24'd0, prg_size_reg};
            CFG_CHR:  prdata = {24'd0, chr_size_reg};
            CFG_FOUR: prdata = {31'd0, four_reg};
            default:  prdata = '0;
        endcase
    end

    assign done      = done_reg;
    assign page      = page_reg;
    assign irq       = irq_reg;
    assign mirroring = mirror_reg;

    // checks
    `BMSI_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `BMSI_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `BMSI_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `BMSI_ASSERT_NOW(a_mod_in_state, clk, rst_n, mod_rsp.done, state_reg == ST_MOD)

endmodule

`default_nettype wire

@@ verif/mapper_result_checker.sv @@
// result checker for the bank mapper core: predicts every transaction and compares
// depends on bmsi_pkg; watches the command, result and apb channels of the core
`timescale 1ns / 1ps

module mapper_result_checker
    import bmsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [2:0]        kind,
    input  logic [15:0]       address,
    input  logic [7:0]        data,
    input  logic [8:0]        scanline,
    input  logic              rendering_on,
    input  logic              done,
    input  logic [PAGE_W-1:0] page,
    input  logic              irq,
    input  logic              mirroring,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    // program bank registers and the pattern pair registers
    localparam int PRG_BANK_A = 6;
    localparam int PRG_BANK_B = 7;
    localparam int PAIR_BANKS = 2;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              irq;
        logic              mirroring;
    } mapper_result_t;

    mapper_result_t expected_results[$];
    int             failures = 0;
    int             waiting = 0;

    // shadow of the mapper state and its configuration
    logic [7:0] bank_q [NUM_BANK_REGS];
    logic [2:0] sel_idx;
    logic       chr_swap_q;
    logic       prg_swap_q;
    logic [7:0] irq_cnt;
    logic [7:0] irq_rld;
    logic       irq_en;
    logic       mirror_q;
    logic [7:0] prg_units;
    logic [7:0] chr_units;
    logic       four_q;

    assign fail_count = failures;
    assign pending    = waiting;

    task automatic note_failure(input string msg);
        if (failures < 10)
        begin
            $display("%t: %s", $realtime, msg);
        end
        failures++;
    endtask

    // 8KB program page for a cpu address
    function automatic logic [PAGE_W-1:0] cpu_lookup(input logic [15:0] a);
        logic [PAGE_W-1:0] pages;
        logic [PAGE_W-1:0] last_pg;
        logic [PAGE_W-1:0] second_pg;
        pages     = {prg_units, 1'b0};
        last_pg   = pages - 9'd1;
        second_pg = pages - 9'd2;
        if (a < CPU_ROM_BASE)
        begin
            return '0;
        end
        case (a[14:13])
            2'd0:    return prg_swap_q ? second_pg : {1'b0, bank_q[PRG_BANK_A]};
            2'd1:    return {1'b0, bank_q[PRG_BANK_B]};
            2'd2:    return prg_swap_q ? {1'b0, bank_q[PRG_BANK_A]} : second_pg;
            default: return last_pg;
        endcase
    endfunction

    // 1KB pattern page for a ppu address
    function automatic logic [PAGE_W-1:0] ppu_lookup(input logic [15:0] a);
        logic [2:0] slot;
        if (a >= PPU_TOP)
        begin
            return '0;
        end
        slot = a[12:10];
        if (chr_swap_q)
        begin
            slot = slot ^ 3'b100;
        end
        // low half uses the 2KB pairs, high half the single 1KB banks
        if (!slot[2])
        begin
            return {1'b0, bank_q[slot[1]]} + {8'd0, slot[0]};
        end
        return {1'b0, bank_q[slot - 3'd2]};
    endfunction

    // apply one transaction to the shadow state and give its result
    function automatic void mapper_step(input logic [2:0] k, input logic [15:0] a,
                                        input logic [7:0] d, input logic [8:0] line,
                                        input logic rend, output mapper_result_t res);
        int m;
        int v;
        res = '0;
        case (k)
            KIND_WRITE:
            begin
                case (a & DEC_MASK)
                    DEC_MIRROR:
                    begin
                        if (!four_q)
                        begin
                            mirror_q = d[0];
                        end
                    end
                    DEC_IRQ_CNT:  irq_cnt = d;
                    DEC_IRQ_RLD:  irq_rld = d;
                    DEC_IRQ_OFF:  irq_en = 1'b0;
                    DEC_IRQ_ON:   irq_en = 1'b1;
                    DEC_BANK_SEL:
                    begin
                        chr_swap_q = d[7];
                        prg_swap_q = d[6];
                        sel_idx    = d[2:0];
                    end
                    DEC_BANK_DAT:
                    begin
                        if (sel_idx >= PRG_BANK_A)
                        begin
                            // zero program size keeps the byte as written
                            m = 2 * int'(prg_units);
                            v = (m != 0) ? int'(d) % m : int'(d);
                            bank_q[sel_idx] = v[7:0];
                        end
                        else if (chr_units != 8'd0)
                        begin
                            m = 8 * int'(chr_units);
                            v = (sel_idx < PAIR_BANKS) ? int'(d & PAIR_MASK) : int'(d);
                            v = v % m;
                            bank_q[sel_idx] = v[7:0];
                        end
                    end
                    default: ;
                endcase
            end
            KIND_TICK:
            begin
                if (irq_en && line <= TICK_LAST_LINE && rend)
                begin
                    irq_cnt = irq_cnt - 8'd1;
                    if (irq_cnt == 8'd0)
                    begin
                        irq_cnt = irq_rld;
                        res.irq = 1'b1;
                    end
                end
            end
            KIND_FRAME: irq_cnt = irq_rld;
            KIND_CPU:   res.page = cpu_lookup(a);
            KIND_PPU:   res.page = ppu_lookup(a);
            default: ;
        endcase
        res.mirroring = mirror_q;
    endfunction

    // watch config accesses, results and accepted transactions
    always @(posedge clk or negedge rst_n)
    begin
        mapper_result_t want;
        mapper_result_t got;
        logic [31:0]    reg_val;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANK_REGS; i++)
            begin
                bank_q[i] = BANK_RESET[i];
            end
            sel_idx    = '0;
            chr_swap_q = 1'b0;
            prg_swap_q = 1'b0;
            irq_cnt    = '0;
            irq_rld    = '0;
            irq_en     = 1'b0;
            mirror_q   = 1'b0;
            prg_units  = 8'd2;
            chr_units  = 8'd1;
            four_q     = 1'b0;
            expected_results.delete();
            waiting <= 0;
        end
        else
        begin
            // config register write or read-back
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        CFG_PRG:  prg_units = pwdata[7:0];
                        CFG_CHR:  chr_units = pwdata[7:0];
                        CFG_FOUR: four_q = pwdata[0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        CFG_PRG:  reg_val = {24'd0, prg_units};
                        CFG_CHR:  reg_val = {24'd0, chr_units};
                        CFG_FOUR: reg_val = {31'd0, four_q};
                        default:  reg_val = prdata;
                    endcase
                    if (prdata !== reg_val)
                    begin
                        note_failure($sformatf("config read at %0d: expected %0h, got %0h",
                                               paddr, reg_val, prdata));
                    end
                end
            end

            // result transaction against the oldest prediction
            if (done)
            begin
                got = '{page: page, irq: irq, mirroring: mirroring};
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf({"result with nothing expected: ",
                                            "page %0d irq %0b mirroring %0b"},
                                           got.page, got.irq, got.mirroring));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        note_failure($sformatf({"result mismatch: expected page %0d irq %0b ",
                                                "mirroring %0b, got page %0d irq %0b mirroring %0b"},
                                               want.page, want.irq, want.mirroring,
                                               got.page, got.irq, got.mirroring));
                    end
                end
            end

            // accepted command transaction
            if (start && !busy)
            begin
                mapper_step(kind, address, data, scanline, rendering_on, want);
                expected_results.push_back(want);
            end
            waiting <= expected_results.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// testbench top for the bank mapper core: clock, reset, stimulus and verdict
// depends on bmsi_pkg, bank_mapper_scanline_irq_core and mapper_result_checker
`timescale 1ns / 1ps

module tb;
    import bmsi_pkg::*;

    // kinds the core must treat as no-ops
    localparam logic [2:0] KIND_UNUSED_LO = KIND_PPU + 3'd1;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam int         PHASE_ITEMS    = 128;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        kind = '0;
    logic [15:0]       address = '0;
    logic [7:0]        data = '0;
    logic [8:0]        scanline = '0;
    logic              rendering_on = 1'b0;
    logic              done;
    logic [PAGE_W-1:0] page;
    logic              irq;
    logic              mirroring;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    bit                no_gaps = 1'b0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bank_mapper_scanline_irq_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .scanline     (scanline),
        .rendering_on (rendering_on),
        .done         (done),
        .page         (page),
        .irq          (irq),
        .mirroring    (mirroring),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    mapper_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .scanline     (scanline),
        .rendering_on (rendering_on),
        .done         (done),
        .page         (page),
        .irq          (irq),
        .mirroring    (mirroring),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // one command transaction, after a random gap unless gaps are off
    task automatic send_item(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
                             input logic [8:0] line, input logic rend);
        int gap;
        gap = no_gaps ? 0 : int'($urandom_range(0, 15));
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        address      <= a;
        data         <= d;
        scanline     <= line;
        rendering_on <= rend;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // hold off until every predicted result has come back
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // apb access: setup phase, access phase, then idle
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] prg, input logic [7:0] chr, input logic four);
        wait_idle();
        apb_access(1'b1, CFG_PRG, {24'd0, prg});
        apb_access(1'b1, CFG_CHR, {24'd0, chr});
        apb_access(1'b1, CFG_FOUR, {31'd0, four});
        apb_access(1'b0, CFG_PRG, '0);
        apb_access(1'b0, CFG_CHR, '0);
        apb_access(1'b0, CFG_FOUR, '0);
    endtask

    // random address that decodes to the given register
    function automatic logic [15:0] decode_addr(input logic [15:0] pattern);
        logic [15:0] r;
        r = 16'($urandom);
        return (r & ~DEC_MASK) | pattern;
    endfunction

    // mostly well-formed mapper traffic with some noise
    task automatic send_random_traffic(input int count);
        int          sent;
        int          pick;
        logic [15:0] a;
        logic [7:0]  d;
        logic [8:0]  line;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                no_gaps = !no_gaps;
            end
            if ($urandom_range(0, 59) == 0)
            begin
                wait_idle();
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 22)
            begin
                // bank select followed by bank data
                send_item(KIND_WRITE, decode_addr(DEC_BANK_SEL), 8'($urandom), 9'($urandom),
                          1'($urandom));
                send_item(KIND_WRITE, decode_addr(DEC_BANK_DAT), 8'($urandom), 9'($urandom),
                          1'($urandom));
                sent += 2;
            end
            else if (pick < 34)
            begin
                // mirroring and irq control
                case ($urandom_range(0, 4))
                    0:       a = decode_addr(DEC_MIRROR);
                    1:       a = decode_addr(DEC_IRQ_CNT);
                    2:       a = decode_addr(DEC_IRQ_RLD);
                    3:       a = decode_addr(DEC_IRQ_OFF);
                    default: a = decode_addr(DEC_IRQ_ON);
                endcase
                d = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
                send_item(KIND_WRITE, a, d, 9'($urandom), 1'($urandom));
                sent++;
            end
            else if (pick < 62)
            begin
                line = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(0, 239))
                                                  : 9'($urandom_range(0, 511));
                send_item(KIND_TICK, 16'($urandom), 8'($urandom), line,
                          $urandom_range(0, 9) != 0);
                sent++;
            end
            else if (pick < 66)
            begin
                send_item(KIND_FRAME, 16'($urandom), 8'($urandom), 9'($urandom),
                          1'($urandom));
                sent++;
            end
            else if (pick < 79)
            begin
                a = 16'($urandom);
                if ($urandom_range(0, 9) < 8)
                begin
                    a[15] = 1'b1;
                end
                send_item(KIND_CPU, a, 8'($urandom), 9'($urandom), 1'($urandom));
                sent++;
            end
            else if (pick < 92)
            begin
                a = 16'($urandom);
                if ($urandom_range(0, 9) < 8)
                begin
                    a[15:13] = 3'b000;
                end
                send_item(KIND_PPU, a, 8'($urandom), 9'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                send_item(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom),
                          9'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lookups at the edges of both address spaces
        send_item(KIND_CPU, 16'h7fff, 8'd0, 9'd0, 1'b0);
        send_item(KIND_CPU, 16'h8000, 8'd0, 9'd0, 1'b0);
        send_item(KIND_CPU, 16'ha000, 8'd0, 9'd0, 1'b0);
        send_item(KIND_CPU, 16'hc000, 8'd0, 9'd0, 1'b0);
        send_item(KIND_CPU, 16'hffff, 8'd0, 9'd0, 1'b0);
        send_item(KIND_PPU, 16'h0000, 8'd0, 9'd0, 1'b0);
        send_item(KIND_PPU, 16'h1fff, 8'd0, 9'd0, 1'b0);
        send_item(KIND_PPU, PPU_TOP, 8'd0, 9'd0, 1'b0);
        // both swaps, then full-scale bank data into a program and a pair register
        send_item(KIND_WRITE, DEC_BANK_SEL, 8'hc7, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_BANK_DAT, 8'hff, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_BANK_SEL, 8'h00, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_BANK_DAT, 8'hff, 9'd0, 1'b0);
        send_item(KIND_PPU, 16'h0400, 8'd0, 9'd0, 1'b0);
        send_item(KIND_CPU, 16'h8000, 8'd0, 9'd0, 1'b0);
        // mirroring and the ignored sram-enable write
        send_item(KIND_WRITE, DEC_MIRROR, 8'h01, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_MIRROR | 16'h0001, 8'h00, 9'd0, 1'b0);
        // counter wraps from zero, then reaches zero on the last visible line
        send_item(KIND_WRITE, DEC_IRQ_RLD, 8'h00, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_IRQ_CNT, 8'h00, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_IRQ_ON, 8'h00, 9'd0, 1'b0);
        send_item(KIND_TICK, 16'h0000, 8'd0, 9'd0, 1'b1);
        send_item(KIND_WRITE, DEC_IRQ_CNT, 8'h01, 9'd0, 1'b0);
        send_item(KIND_TICK, 16'h0000, 8'd0, TICK_LAST_LINE, 1'b1);
        send_item(KIND_TICK, 16'h0000, 8'd0, TICK_LAST_LINE + 9'd1, 1'b1);
        send_item(KIND_TICK, 16'h0000, 8'd0, 9'd5, 1'b0);
        send_item(KIND_FRAME, 16'h0000, 8'd0, 9'd0, 1'b0);
        send_item(KIND_WRITE, DEC_IRQ_OFF, 8'h00, 9'd0, 1'b0);
        send_item(KIND_UNUSED_LO, 16'hffff, 8'hff, 9'h1ff, 1'b1);
        send_item(KIND_UNUSED_HI, 16'h8001, 8'hff, 9'd0, 1'b1);

        send_random_traffic(PHASE_ITEMS);

        // no pattern rom, four-screen, smallest program
        set_config(8'd1, 8'd0, 1'b1);
        send_random_traffic(PHASE_ITEMS);
        // largest sizes
        set_config(8'd255, 8'd255, 1'b0);
        send_random_traffic(PHASE_ITEMS);
        // zero program size, fixed pages wrap
        set_config(8'd0, 8'd3, 1'b1);
        send_random_traffic(PHASE_ITEMS);
        set_config(8'd128, 8'd128, 1'b0);
        send_random_traffic(PHASE_ITEMS);
        for (int i = 0; i < 3; i++)
        begin
            set_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
            send_random_traffic(PHASE_ITEMS);
        end
        set_config(8'd2, 8'd1, 1'b0);
        send_random_traffic(PHASE_ITEMS);

        // drain and let the core settle
        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
